// File: rtl/core/morse_character_keyer_unit_defines.svh
// assertion macros shared by the keyer rtl
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MCK_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mck check failed");

// next-cycle implication, disabled during reset
`define MCK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mck check failed");

`endif

// File: rtl/core/mck_pkg.sv
// types, constants and lookup tables for the morse keyer
package mck_pkg;

	localparam int TICK_BITS = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int ELEM_W    = 5;
	localparam int LEN_W     = 3;

	localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_BITS) - 64'd1);

	localparam logic [CFG_W-1:0] DOT_ON_RST  = 16'd100;
	localparam logic [CFG_W-1:0] DASH_ON_RST = 16'd500;
	localparam logic [CFG_W-1:0] GAP_RST     = 16'd200;
	localparam logic [CFG_W-1:0] SEP_ON_RST  = 16'd200;

	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] CH_DIGIT_0 = 8'd48;
	localparam logic [7:0] CH_DIGIT_9 = 8'd57;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	localparam logic [LEN_W-1:0] DIGIT_LEN = 3'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DOT_ON,
		REG_DASH_ON,
		REG_GAP,
		REG_SEP_ON
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_CHAR = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_ELEM_ON  = 3'd1,
		PH_ELEM_GAP = 3'd2,
		PH_SEP_GAP1 = 3'd3,
		PH_SEP_ON   = 3'd4,
		PH_SEP_GAP2 = 3'd5
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] dot_on;
		logic [CFG_W-1:0] dash_on;
		logic [CFG_W-1:0] gap;
		logic [CFG_W-1:0] sep_on;
	} cfg_t;

	typedef struct packed {
		logic [ELEM_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} pattern_t;

	typedef struct packed {
		logic main_lamp;
		logic sep_lamp;
		logic busy_res;
		logic accepted;
	} result_t;

	// element pattern per letter, first element in bit 0, 1 = dash
	function automatic logic [ELEM_W-1:0] letter_bits(input logic [4:0] idx);
		logic [ELEM_W-1:0] b;
		case (idx)
			5'd0:  b = 5'd2;
			5'd1:  b = 5'd1;
			5'd2:  b = 5'd5;
			5'd3:  b = 5'd1;
			5'd4:  b = 5'd0;
			5'd5:  b = 5'd4;
			5'd6:  b = 5'd3;
			5'd7:  b = 5'd0;
			5'd8:  b = 5'd0;
			5'd9:  b = 5'd14;
			5'd10: b = 5'd5;
			5'd11: b = 5'd2;
			5'd12: b = 5'd3;
			5'd13: b = 5'd1;
			5'd14: b = 5'd7;
			5'd15: b = 5'd6;
			5'd16: b = 5'd11;
			5'd17: b = 5'd2;
			5'd18: b = 5'd0;
			5'd19: b = 5'd1;
			5'd20: b = 5'd4;
			5'd21: b = 5'd8;
			5'd22: b = 5'd6;
			5'd23: b = 5'd9;
			5'd24: b = 5'd13;
			5'd25: b = 5'd3;
			default: b = 5'd0;
		endcase
		return b;
	endfunction

	function automatic logic [LEN_W-1:0] letter_len(input logic [4:0] idx);
		logic [LEN_W-1:0] n;
		case (idx)
			5'd0:  n = 3'd2;
			5'd1:  n = 3'd4;
			5'd2:  n = 3'd4;
			5'd3:  n = 3'd3;
			5'd4:  n = 3'd1;
			5'd5:  n = 3'd4;
			5'd6:  n = 3'd3;
			5'd7:  n = 3'd4;
			5'd8:  n = 3'd2;
			5'd9:  n = 3'd4;
			5'd10: n = 3'd3;
			5'd11: n = 3'd4;
			5'd12: n = 3'd2;
			5'd13: n = 3'd2;
			5'd14: n = 3'd3;
			5'd15: n = 3'd4;
			5'd16: n = 3'd4;
			5'd17: n = 3'd3;
			5'd18: n = 3'd3;
			5'd19: n = 3'd1;
			5'd20: n = 3'd3;
			5'd21: n = 3'd4;
			5'd22: n = 3'd3;
			5'd23: n = 3'd4;
			5'd24: n = 3'd4;
			5'd25: n = 3'd4;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [ELEM_W-1:0] digit_bits(input logic [3:0] idx);
		logic [ELEM_W-1:0] b;
		case (idx)
			4'd0: b = 5'd31;
			4'd1: b = 5'd30;
			4'd2: b = 5'd28;
			4'd3: b = 5'd24;
			4'd4: b = 5'd16;
			4'd5: b = 5'd0;
			4'd6: b = 5'd1;
			4'd7: b = 5'd3;
			4'd8: b = 5'd7;
			4'd9: b = 5'd15;
			default: b = 5'd0;
		endcase
		return b;
	endfunction

	// segment length from a register: zero counts as one, clamp to the counter
	function automatic logic [TICK_BITS-1:0] seg_len(input logic [CFG_W-1:0] r);
		logic [31:0] w;
		w = 32'(r);
		if (w == 32'd0) begin
			w = 32'd1;
		end
		if (w > TICK_MAX) begin
			w = TICK_MAX;
		end
		return w[TICK_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/mck_if.sv
// handshake channel interfaces for the morse keyer
interface mck_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface mck_result_if;
	logic valid;
	logic ready;
	logic main_lamp;
	logic sep_lamp;
	logic busy_res;
	logic accepted;

	modport source (output valid, output main_lamp, output sep_lamp, output busy_res,
		output accepted, input ready);
	modport sink (input valid, input main_lamp, input sep_lamp, input busy_res,
		input accepted, output ready);
endinterface

interface mck_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mck_pkg::CFG_IDX_W-1:0] index;
	logic [mck_pkg::CFG_W-1:0]     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/core/mck_cfg_regs.sv
// timing registers of the morse keyer
module mck_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mck_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [mck_pkg::CFG_W-1:0]     wr_data,
	output mck_pkg::cfg_t                 cfg
);

	mck_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dot_on  <= mck_pkg::DOT_ON_RST;
			cfg_q.dash_on <= mck_pkg::DASH_ON_RST;
			cfg_q.gap     <= mck_pkg::GAP_RST;
			cfg_q.sep_on  <= mck_pkg::SEP_ON_RST;
		end else if (wr_en) begin
			case (mck_pkg::cfg_reg_t'(wr_index))
				mck_pkg::REG_DOT_ON:  cfg_q.dot_on  <= wr_data;
				mck_pkg::REG_DASH_ON: cfg_q.dash_on <= wr_data;
				mck_pkg::REG_GAP:     cfg_q.gap     <= wr_data;
				mck_pkg::REG_SEP_ON:  cfg_q.sep_on  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/mck_char_decode.sv
// character to element pattern lookup
module mck_char_decode (
	input  logic [7:0]        char_code,
	output mck_pkg::pattern_t pattern
);

	logic [7:0] folded;
	logic [7:0] letter_off;
	logic [7:0] digit_off;

	always_comb begin
		folded = char_code;
		if (char_code inside {[mck_pkg::CH_UPPER_A:mck_pkg::CH_UPPER_Z]}) begin
			folded = char_code + mck_pkg::CASE_BIT;
		end
	end

	assign letter_off = folded - mck_pkg::CH_LOWER_A;
	assign digit_off  = folded - mck_pkg::CH_DIGIT_0;

	always_comb begin
		if (folded inside {[mck_pkg::CH_LOWER_A:mck_pkg::CH_LOWER_Z]}) begin
			pattern.bits = mck_pkg::letter_bits(letter_off[4:0]);
			pattern.len  = mck_pkg::letter_len(letter_off[4:0]);
		end else if (folded inside {[mck_pkg::CH_DIGIT_0:mck_pkg::CH_DIGIT_9]}) begin
			pattern.bits = mck_pkg::digit_bits(digit_off[3:0]);
			pattern.len  = mck_pkg::DIGIT_LEN;
		end else begin
			pattern.bits = '0;
			pattern.len  = '0;
		end
	end

endmodule

// File: rtl/core/mck_keyer_fsm.sv
// keying state machine: phase, element shift register and segment counter
`include "morse_character_keyer_unit_defines.svh"

module mck_keyer_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              opcode,
	input  mck_pkg::pattern_t pattern,
	input  mck_pkg::cfg_t     cfg,
	output mck_pkg::result_t  res
);

	mck_pkg::phase_t                   phase_q;
	mck_pkg::phase_t                   phase_d;
	logic [mck_pkg::ELEM_W-1:0]        bits_q;
	logic [mck_pkg::ELEM_W-1:0]        bits_d;
	logic [mck_pkg::LEN_W-1:0]         left_q;
	logic [mck_pkg::LEN_W-1:0]         left_d;
	logic [mck_pkg::TICK_BITS-1:0]     count_q;
	logic [mck_pkg::TICK_BITS-1:0]     count_d;
	logic                              acc_d;
	logic [mck_pkg::ELEM_W-1:0]        bits_shift;
	logic [mck_pkg::LEN_W-1:0]         left_dec;

	assign bits_shift = {1'b0, bits_q[mck_pkg::ELEM_W-1:1]};
	assign left_dec   = (left_q != '0) ? left_q - 1'b1 : '0;

	// next state
	always_comb begin
		phase_d = phase_q;
		bits_d  = bits_q;
		left_d  = left_q;
		count_d = count_q;
		acc_d   = 1'b0;
		if (opcode == mck_pkg::OP_CHAR) begin
			if (phase_q == mck_pkg::PH_IDLE) begin
				acc_d  = 1'b1;
				bits_d = pattern.bits;
				left_d = pattern.len;
				if (pattern.len != '0) begin
					phase_d = mck_pkg::PH_ELEM_ON;
					count_d = mck_pkg::seg_len(pattern.bits[0] ? cfg.dash_on : cfg.dot_on);
				end else begin
					phase_d = mck_pkg::PH_SEP_GAP1;
					count_d = mck_pkg::seg_len(cfg.gap);
				end
			end
		end else if (phase_q != mck_pkg::PH_IDLE) begin
			if (count_q <= mck_pkg::TICK_BITS'(1)) begin
				case (phase_q)
					mck_pkg::PH_ELEM_ON: begin
						phase_d = mck_pkg::PH_ELEM_GAP;
						count_d = mck_pkg::seg_len(cfg.gap);
					end
					mck_pkg::PH_ELEM_GAP: begin
						bits_d = bits_shift;
						left_d = left_dec;
						if (left_dec != '0) begin
							phase_d = mck_pkg::PH_ELEM_ON;
							count_d = mck_pkg::seg_len(bits_shift[0] ? cfg.dash_on : cfg.dot_on);
						end else begin
							phase_d = mck_pkg::PH_SEP_GAP1;
							count_d = mck_pkg::seg_len(cfg.gap);
						end
					end
					mck_pkg::PH_SEP_GAP1: begin
						phase_d = mck_pkg::PH_SEP_ON;
						count_d = mck_pkg::seg_len(cfg.sep_on);
					end
					mck_pkg::PH_SEP_ON: begin
						phase_d = mck_pkg::PH_SEP_GAP2;
						count_d = mck_pkg::seg_len(cfg.gap);
					end
					default: begin
						phase_d = mck_pkg::PH_IDLE;
						bits_d  = '0;
						left_d  = '0;
						count_d = '0;
					end
				endcase
			end else begin
				count_d = count_q - 1'b1;
			end
		end
	end

	// outputs show the state after this transaction
	always_comb begin
		res.main_lamp = (phase_d == mck_pkg::PH_ELEM_ON);
		res.sep_lamp  = (phase_d == mck_pkg::PH_SEP_ON);
		res.busy_res  = (phase_d != mck_pkg::PH_IDLE);
		res.accepted  = acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mck_pkg::PH_IDLE;
			bits_q  <= '0;
			left_q  <= '0;
			count_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			bits_q  <= bits_d;
			left_q  <= left_d;
			count_q <= count_d;
		end
	end

	`MCK_ASSERT_HOLDS(a_idle_clear, clk, arst_n, phase_q == mck_pkg::PH_IDLE,
		bits_q == '0 && left_q == '0 && count_q == '0)
	`MCK_ASSERT_HOLDS(a_busy_count, clk, arst_n, phase_q != mck_pkg::PH_IDLE, count_q != '0)
	`MCK_ASSERT_HOLDS(a_elem_left, clk, arst_n,
		phase_q == mck_pkg::PH_ELEM_ON || phase_q == mck_pkg::PH_ELEM_GAP, left_q != '0)

endmodule

// File: rtl/core/morse_character_keyer_unit.sv
// Morse character keyer. Each item on the input channel is either a character offer or
// one time tick; each gives exactly one result with the lamp and busy state after it and
// whether the offer was taken. The block takes one item per clock cycle when not stalled;
// an input register holds the item, and a single-pass update of the keying state (phase,
// element shift register, tick counter) writes the result register. Back-pressure on the
// result channel stalls the input register and the keying state; a full result register
// that is not taken and a full input register together drop ready. Timing registers are
// written through the configuration channel, which is always ready.
`include "morse_character_keyer_unit_defines.svh"

module morse_character_keyer_unit (
	input logic          clk,
	input logic          arst_n,
	mck_item_if.sink     item,
	mck_result_if.source result,
	mck_cfg_if.sink      cfg
);

	logic              valid_s1;
	logic              opcode_s1;
	logic [7:0]        char_s1;
	logic              valid_s2;
	mck_pkg::result_t  res_s2;
	logic              adv;
	mck_pkg::cfg_t     cfg_vals;
	mck_pkg::pattern_t pattern;
	mck_pkg::result_t  res_d;

	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			opcode_s1 <= item.opcode;
			char_s1   <= item.char_code;
		end
	end

	mck_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.wdata),
		.cfg      (cfg_vals)
	);

	mck_char_decode u_char_decode (
		.char_code (char_s1),
		.pattern   (pattern)
	);

	mck_keyer_fsm u_keyer_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.opcode  (opcode_s1),
		.pattern (pattern),
		.cfg     (cfg_vals),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid     = valid_s2;
	assign result.main_lamp = res_s2.main_lamp;
	assign result.sep_lamp  = res_s2.sep_lamp;
	assign result.busy_res  = res_s2.busy_res;
	assign result.accepted  = res_s2.accepted;

	`MCK_ASSERT_HOLDS(a_acc_busy, clk, arst_n, valid_s2 && res_s2.accepted, res_s2.busy_res)
	`MCK_ASSERT_HOLDS(a_lamps_excl, clk, arst_n, valid_s2,
		!(res_s2.main_lamp && res_s2.sep_lamp) && (res_s2.busy_res || !res_s2.main_lamp))
	`MCK_ASSERT_NEXT(a_adv_fills, clk, arst_n, adv, valid_s2)

endmodule

// File: tb/morse_character_keyer_unit_checker.sv
// result checker for the morse keyer: tracks keying state per transaction and compares results
module morse_character_keyer_unit_checker (
	input  logic   clk,
	input  logic   arst_n,
	mck_item_if    item,
	mck_result_if  result,
	mck_cfg_if     cfg,
	output int     mismatches,
	output int     waiting,
	output int     checked
);
	import mck_pkg::*;

	cfg_t                 timing;
	phase_t               ph;
	logic [ELEM_W-1:0]    dashes;
	logic [LEN_W-1:0]     left;
	logic [TICK_BITS-1:0] remaining;
	result_t              lamp_q [$];

	// dot/dash string per letter a..z, then digits 0..9
	function automatic string morse_of(input int idx);
		string s;
		case (idx)
			0: s = ".-";
			1: s = "-...";
			2: s = "-.-.";
			3: s = "-..";
			4: s = ".";
			5: s = "..-.";
			6: s = "--.";
			7: s = "....";
			8: s = "..";
			9: s = ".---";
			10: s = "-.-";
			11: s = ".-..";
			12: s = "--";
			13: s = "-.";
			14: s = "---";
			15: s = ".--.";
			16: s = "--.-";
			17: s = ".-.";
			18: s = "...";
			19: s = "-";
			20: s = "..-";
			21: s = "...-";
			22: s = ".--";
			23: s = "-..-";
			24: s = "-.--";
			25: s = "--..";
			26: s = "-----";
			27: s = ".----";
			28: s = "..---";
			29: s = "...--";
			30: s = "....-";
			31: s = ".....";
			32: s = "-....";
			33: s = "--...";
			34: s = "---..";
			35: s = "----.";
			default: s = "";
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] result %0d: %s", $time, checked, what);
		mismatches++;
	endtask

	task automatic compare_bit(input string name, input logic got, input logic want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
		end
	endtask

	// zero length counts as one tick
	task automatic load_segment(input phase_t p, input logic [CFG_W-1:0] r);
		ph = p;
		remaining = (r == '0) ? TICK_BITS'(1) : TICK_BITS'(r);
	endtask

	task automatic start_element();
		load_segment(PH_ELEM_ON, dashes[0] ? timing.dash_on : timing.dot_on);
	endtask

	task automatic next_segment();
		case (ph)
			PH_ELEM_ON: load_segment(PH_ELEM_GAP, timing.gap);
			PH_ELEM_GAP: begin
				dashes = dashes >> 1;
				left = (left != '0) ? left - 1'b1 : '0;
				if (left != '0) begin
					start_element();
				end else begin
					load_segment(PH_SEP_GAP1, timing.gap);
				end
			end
			PH_SEP_GAP1: load_segment(PH_SEP_ON, timing.sep_on);
			PH_SEP_ON: load_segment(PH_SEP_GAP2, timing.gap);
			default: begin
				ph = PH_IDLE;
				dashes = '0;
				left = '0;
				remaining = '0;
			end
		endcase
	endtask

	task automatic key_item(input logic op, input logic [7:0] ch);
		result_t    after;
		logic [7:0] c;
		string      code;
		int         i;
		after = '0;
		if (op == OP_CHAR) begin
			if (ph == PH_IDLE) begin
				after.accepted = 1'b1;
				c = ch;
				if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
					c = c + CASE_BIT;
				end
				code = "";
				if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
					code = morse_of(int'(c - CH_LOWER_A));
				end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
					code = morse_of(26 + int'(c - CH_DIGIT_0));
				end
				dashes = '0;
				for (i = 0; i < code.len(); i++) begin
					dashes[i] = (code[i] == "-");
				end
				left = LEN_W'(code.len());
				// anything else keys the separator alone
				if (left != '0) begin
					start_element();
				end else begin
					load_segment(PH_SEP_GAP1, timing.gap);
				end
			end
		end else if (ph != PH_IDLE) begin
			if (remaining <= 1) begin
				next_segment();
			end else begin
				remaining = remaining - 1'b1;
			end
		end
		after.main_lamp = (ph == PH_ELEM_ON);
		after.sep_lamp  = (ph == PH_SEP_ON);
		after.busy_res  = (ph != PH_IDLE);
		lamp_q.push_back(after);
	endtask

	task automatic check_result();
		result_t want;
		if (lamp_q.size() == 0) begin
			report_mismatch("result with no transaction waiting for it");
		end else begin
			want = lamp_q.pop_front();
			compare_bit("main_lamp", result.main_lamp, want.main_lamp);
			compare_bit("sep_lamp", result.sep_lamp, want.sep_lamp);
			compare_bit("busy_res", result.busy_res, want.busy_res);
			compare_bit("accepted", result.accepted, want.accepted);
		end
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing     = '{DOT_ON_RST, DASH_ON_RST, GAP_RST, SEP_ON_RST};
			ph         = PH_IDLE;
			dashes     = '0;
			left       = '0;
			remaining  = '0;
			lamp_q.delete();
			mismatches = 0;
			checked    = 0;
			waiting    = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_DOT_ON:  timing.dot_on  = cfg.wdata;
					REG_DASH_ON: timing.dash_on = cfg.wdata;
					REG_GAP:     timing.gap     = cfg.wdata;
					REG_SEP_ON:  timing.sep_on  = cfg.wdata;
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				key_item(item.opcode, item.char_code);
			end
			if (result.valid && result.ready) begin
				check_result();
			end
			waiting = lamp_q.size();
		end
	end

endmodule

// File: tb/morse_character_keyer_unit_tb.sv
// testbench top for the morse keyer: drives characters, ticks and timing writes, gives the verdict
module morse_character_keyer_unit_tb;
	import mck_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   waiting;
	int   checked;
	int   n_ticks;
	int   n_offers;
	int   n_settings;
	int   stall_left;
	bit   quiet;
	cfg_t timing;

	mck_item_if   item ();
	mck_result_if result ();
	mck_cfg_if    cfg ();

	morse_character_keyer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	morse_character_keyer_unit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.cfg        (cfg),
		.mismatches (mismatches),
		.waiting    (waiting),
		.checked    (checked)
	);

	always begin
		#10;
		clk = 1'b1;
		#10;
		clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("morse_character_keyer_unit: mismatch");
		$finish;
	end

	// mostly no pause, sometimes a short one, rarely a long one
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_char();
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			c = CH_LOWER_A + 8'($urandom_range(0, 25));
			if ($urandom_range(0, 1) == 1) begin
				c = c - CASE_BIT;
			end
		end else if (r < 70) begin
			c = CH_DIGIT_0 + 8'($urandom_range(0, 9));
		end else begin
			c = 8'($urandom_range(0, 255));
		end
		return c;
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return CFG_W'($urandom_range(4, 9));
		end
		return CFG_W'($urandom_range(1, 3));
	endfunction

	// ticks that always suffice to key the longest character to the end
	function automatic int char_ticks_max();
		int dot, dash, gap, sep;
		dot  = (timing.dot_on == '0) ? 1 : int'(timing.dot_on);
		dash = (timing.dash_on == '0) ? 1 : int'(timing.dash_on);
		gap  = (timing.gap == '0) ? 1 : int'(timing.gap);
		sep  = (timing.sep_on == '0) ? 1 : int'(timing.sep_on);
		return 5 * ((dot > dash ? dot : dash) + gap) + 2 * gap + sep + 1;
	endfunction

	task automatic send_item(input opcode_t op, input logic [7:0] ch);
		int k;
		k = quiet ? 0 : pause_len();
		if (k > 0) begin
			item.valid <= 1'b0;
			repeat (k) @(negedge clk);
		end
		item.valid     <= 1'b1;
		item.opcode    <= op;
		item.char_code <= ch;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
		if (op == OP_TICK) begin
			n_ticks++;
		end else begin
			n_offers++;
		end
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(OP_TICK, 8'($urandom));
	endtask

	task automatic wait_drained();
		item.valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [CFG_W-1:0] dot, dash, gap, sep);
		write_reg(REG_DOT_ON, dot);
		write_reg(REG_DASH_ON, dash);
		write_reg(REG_GAP, gap);
		write_reg(REG_SEP_ON, sep);
		cfg.valid <= 1'b0;
		timing = '{dot, dash, gap, sep};
		n_settings++;
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			result.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result.ready <= 1'b0;
			stall_left--;
		end else begin
			result.ready <= 1'b1;
			if ($urandom_range(0, 7) == 0) begin
				stall_left = 1 + pause_len();
			end
		end
	end

	initial begin
		byte unsigned corner_chars [$];
		int           target;
		int           k;
		arst_n         = 1'b0;
		quiet          = 1'b1;
		stall_left     = 0;
		n_ticks        = 0;
		n_offers       = 0;
		n_settings     = 1;
		item.valid     = 1'b0;
		item.opcode    = OP_TICK;
		item.char_code = 8'h00;
		result.ready   = 1'b1;
		cfg.valid      = 1'b0;
		cfg.index      = REG_DOT_ON;
		cfg.wdata      = '0;
		timing         = '{DOT_ON_RST, DASH_ON_RST, GAP_RST, SEP_ON_RST};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset timing: tick while idle, one letter, a refused offer
		send_item(OP_TICK, 8'h00);
		send_item(OP_CHAR, "E");
		send_item(OP_CHAR, "T");
		send_ticks(5);
		wait_drained();

		// shortest timing written mid-dot, the rest of the letter uses it
		set_timing(16'd1, 16'd1, 16'd1, 16'd1);
		send_ticks(int'(DOT_ON_RST) + char_ticks_max());
		wait_drained();

		// letters, digits, their neighbors and the byte extremes
		quiet = 1'b0;
		corner_chars = {"A", "Z", "a", "z", "0", "9", "@", "[", 8'h60, "{", "/", ":", " ",
			8'h00, 8'hFF, "M"};
		foreach (corner_chars[i]) begin
			send_item(OP_CHAR, corner_chars[i]);
			send_item(OP_TICK, 8'hFF);
			send_item(OP_CHAR, "E");
			send_ticks(char_ticks_max());
		end
		wait_drained();

		// zero lengths behave as one tick
		set_timing(16'd0, 16'd0, 16'd0, 16'd0);
		send_item(OP_CHAR, "0");
		send_ticks(char_ticks_max());
		send_item(OP_CHAR, "q");
		send_ticks(char_ticks_max());
		wait_drained();

		for (int s = 0; s < 6; s++) begin
			set_timing(pick_reg(), pick_reg(), pick_reg(), pick_reg());
			quiet  = ($urandom_range(0, 3) == 0);
			target = n_ticks + n_offers + 50;
			while (n_ticks + n_offers < target) begin
				send_item(OP_CHAR, pick_char());
				if ($urandom_range(0, 4) == 0) begin
					k = $urandom_range(0, char_ticks_max());
				end else begin
					k = $urandom_range(char_ticks_max() / 2, char_ticks_max());
				end
				repeat (k) begin
					if ($urandom_range(0, 19) == 0) begin
						send_item(OP_CHAR, pick_char());
					end else begin
						send_item(OP_TICK, 8'($urandom));
					end
				end
				if ($urandom_range(0, 24) == 0) begin
					wait_drained();
				end
			end
			send_ticks(char_ticks_max());
			wait_drained();
		end

		// longest separator pulse the counter holds, still lit at the end
		set_timing(16'd1, 16'd1, 16'd1, 16'hFFFF);
		quiet = 1'b1;
		send_item(OP_CHAR, "E");
		send_ticks(20);
		send_item(OP_CHAR, "A");
		send_ticks(4);
		wait_drained();

		repeat (8) @(negedge clk);
		$display("keyed %0d character offers with %0d ticks under %0d timing settings",
			n_offers, n_ticks, n_settings);
		$display("%0d results compared in order, %0d field errors", checked, mismatches);
		if (mismatches == 0) begin
			$display("morse_character_keyer_unit: match");
		end else begin
			$display("morse_character_keyer_unit: mismatch");
		end
		$finish;
	end

endmodule
